FILE: rtl/prtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package prtu_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 2'd2;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  localparam logic [4:0] OB_MIN = 5'd1;
  localparam logic [4:0] OB_MAX = 5'd24;

  localparam int unsigned RANK_W = 6;
  localparam logic [RANK_W-1:0] RANK_MAX = 6'd63;

  typedef enum logic [2:0] {
    SRC_HIT,
    SRC_FREE,
    SRC_LRU,
    SRC_FIFO,
    SRC_CLOCK
  } prtu_src_e;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      pick;
    prtu_src_e src;
    logic      sweep_init;
    logic      sweep_step;
    logic      vread;
    logic      vcap;
    logic      update;
    logic      touch;
    logic      finish;
  } prtu_cmd_t;

  typedef struct packed {
    logic       pass_done;
    logic       hit_found;
    logic       free_found;
    logic       use_at_hand;
    logic [1:0] policy;
  } prtu_status_t;

endpackage
`default_nettype wire

FILE: rtl/page_table_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel        Signals                                      Transfer
// access in      start, busy, logical_address_i, is_write_i    start && !busy
// result out     result_valid_o, physical_address_o .. dirty    one-cycle strobe
// configuration  cfg_we_i, cfg_idx_i, cfg_data_i               cfg_we_i, no wait
//
// One transaction at a time, n the active frame count. Each one runs a tag search over
// the n frames, decide, update, an LRU ageing pass over the n frames and finish; both
// passes go through registered memory reads. An eviction adds a read and a capture of
// the victim; a clock eviction first sweeps the hand, which passes at most n frames.
// Reset clears every valid, dirty and use flag at once; tags and ranks are read only
// for resident frames. The receiver cannot stall: each result shows for one cycle, and
// the next transaction can be taken in the cycle after the strobe at the earliest.
module page_table_replacement_unit #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned IDXW      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [prtu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [prtu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                             start,
  output logic                            busy,
  input  wire  [ADDR_BITS-1:0]            logical_address_i,
  input  wire                             is_write_i,
  output logic                            result_valid_o,
  output logic [ADDR_BITS-1:0]            physical_address_o,
  output logic [IDXW-1:0]                 frame_index_o,
  output logic                            page_fault_o,
  output logic                            evict_valid_o,
  output logic [ADDR_BITS-2:0]            evicted_page_o,
  output logic                            dirty_evict_o
);
  import prtu_pkg::*;

  // commands flow down to the datapath, status flows back
  prtu_cmd_t    cmd;
  prtu_status_t status;

  prtu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  prtu_dpath #(
    .FRAMES    (FRAMES),
    .ADDR_BITS (ADDR_BITS),
    .IDXW      (IDXW)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .logical_address_i  (logical_address_i),
    .is_write_i         (is_write_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .physical_address_o (physical_address_o),
    .frame_index_o      (frame_index_o),
    .page_fault_o       (page_fault_o),
    .evict_valid_o      (evict_valid_o),
    .evicted_page_o     (evicted_page_o),
    .dirty_evict_o      (dirty_evict_o)
  );

endmodule
`default_nettype wire

FILE: rtl/prtu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module prtu_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  prtu_pkg::prtu_status_t status_i,
  output prtu_pkg::prtu_cmd_t    cmd_o,
  output logic                  busy_o,
  output logic                  result_valid_o
);
  import prtu_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_SWEEP  = 4'd3;
  localparam logic [3:0] ST_VREAD  = 4'd4;
  localparam logic [3:0] ST_VCAP   = 4'd5;
  localparam logic [3:0] ST_UPDATE = 4'd6;
  localparam logic [3:0] ST_TOUCH  = 4'd7;
  localparam logic [3:0] ST_FINISH = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src = SRC_HIT;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.pass_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.hit_found) begin
          cmd_o.pick = 1'b1;
          cmd_o.src  = SRC_HIT;
          state_d    = ST_UPDATE;
        end else if (status_i.free_found) begin
          cmd_o.pick = 1'b1;
          cmd_o.src  = SRC_FREE;
          state_d    = ST_UPDATE;
        end else if (status_i.policy == POL_LRU) begin
          cmd_o.pick = 1'b1;
          cmd_o.src  = SRC_LRU;
          state_d    = ST_VREAD;
        end else if (status_i.policy == POL_CLOCK) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = ST_SWEEP;
        end else begin
          cmd_o.pick = 1'b1;
          cmd_o.src  = SRC_FIFO;
          state_d    = ST_VREAD;
        end
      end
      ST_SWEEP: begin
        if (status_i.use_at_hand) begin
          cmd_o.sweep_step = 1'b1;
        end else begin
          cmd_o.pick = 1'b1;
          cmd_o.src  = SRC_CLOCK;
          state_d    = ST_VREAD;
        end
      end
      ST_VREAD: begin
        cmd_o.vread = 1'b1;
        state_d     = ST_VCAP;
      end
      ST_VCAP: begin
        cmd_o.vcap = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_TOUCH;
      end
      ST_TOUCH: begin
        cmd_o.touch = 1'b1;
        if (status_i.pass_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_FINISH);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !result_valid_o))
    else $error("accepted transaction did not start work");
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && !status_i.use_at_hand) |=> (state_q == ST_VREAD))
    else $error("clock sweep did not stop at a clear use flag");
  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o)
    else $error("result strobe not followed by idle");

endmodule
`default_nettype wire

FILE: rtl/prtu_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module prtu_dpath #(
  parameter int unsigned FRAMES    = 64,
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned IDXW      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [prtu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [prtu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire  [ADDR_BITS-1:0]             logical_address_i,
  input  wire                              is_write_i,
  input  prtu_pkg::prtu_cmd_t              cmd_i,
  output prtu_pkg::prtu_status_t           status_o,
  output logic [ADDR_BITS-1:0]             physical_address_o,
  output logic [IDXW-1:0]                  frame_index_o,
  output logic                             page_fault_o,
  output logic                             evict_valid_o,
  output logic [ADDR_BITS-2:0]             evicted_page_o,
  output logic                             dirty_evict_o
);
  import prtu_pkg::*;

  localparam int unsigned CNTW = $clog2(FRAMES + 1);

  // configuration
  logic [4:0] ob_cfg_q;
  logic [6:0] fiu_cfg_q;
  logic [1:0] pol_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cfg_q  <= 5'd12;
      fiu_cfg_q <= 7'd64;
      pol_cfg_q <= POL_FIFO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_BITS:   ob_cfg_q  <= cfg_data_i[4:0];
        CFG_FRAMES_IN_USE: fiu_cfg_q <= cfg_data_i[6:0];
        CFG_POLICY:        pol_cfg_q <= cfg_data_i[1:0];
        default:           ;
      endcase
    end
  end

  logic [4:0]      ob;
  logic [CNTW-1:0] n;

  always_comb begin
    if (ob_cfg_q < OB_MIN)      ob = OB_MIN;
    else if (ob_cfg_q > OB_MAX) ob = OB_MAX;
    else                        ob = ob_cfg_q;
    if (fiu_cfg_q == 7'd0)                n = CNTW'(1);
    else if (32'(fiu_cfg_q) > FRAMES)     n = CNTW'(FRAMES);
    else                                  n = CNTW'(fiu_cfg_q);
  end

  function automatic logic [IDXW-1:0] wrap_next(input logic [IDXW-1:0] idx,
                                                input logic [CNTW-1:0] lim);
    logic [CNTW:0] nx;
    nx = (CNTW+1)'(idx) + 1'b1;
    return (nx < (CNTW+1)'(lim)) ? nx[IDXW-1:0] : '0;
  endfunction

  function automatic logic [IDXW-1:0] in_range(input logic [IDXW-1:0] idx,
                                               input logic [CNTW-1:0] lim);
    return ((CNTW+1)'(idx) < (CNTW+1)'(lim)) ? idx : '0;
  endfunction

  // latched transaction
  logic [ADDR_BITS-2:0] page_q;
  logic [ADDR_BITS-1:0] offset_q;
  logic                 wr_q;
  logic [ADDR_BITS-1:0] shifted;
  logic [ADDR_BITS-1:0] off_mask;

  assign shifted  = logical_address_i >> ob;
  assign off_mask = (ADDR_BITS'(1) << ob) - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q   <= shifted[ADDR_BITS-2:0];
      offset_q <= logical_address_i & off_mask;
      wr_q     <= is_write_i;
    end
  end

  // flag vectors
  logic [FRAMES-1:0] valid_q, dirty_q, use_q;

  // tag and rank memories
  logic [ADDR_BITS-2:0] tag_mem  [FRAMES];
  logic [RANK_W-1:0]    rank_mem [FRAMES];
  logic [ADDR_BITS-2:0] tag_rd_q;
  logic [RANK_W-1:0]    rank_rd_q;
  logic [IDXW-1:0]      raddr;
  logic                 rank_we;
  logic [IDXW-1:0]      rank_waddr;
  logic [RANK_W-1:0]    rank_wdata;
  logic                 tag_we;

  // pass counter shared by the search and the ageing pass
  logic [CNTW-1:0] cnt_q;
  logic            pend_q;
  logic [IDXW-1:0] eidx_q;
  logic            pass_run;

  assign pass_run = cmd_i.scan || cmd_i.touch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      eidx_q <= '0;
    end else if (cmd_i.load || cmd_i.update) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else if (pass_run) begin
      pend_q <= (cnt_q < n);
      eidx_q <= cnt_q[IDXW-1:0];
      if (cnt_q < n) cnt_q <= cnt_q + 1'b1;
    end
  end

  // frame choice
  logic [IDXW-1:0]   frame_q, hit_idx_q, free_idx_q, best_idx_q, hand_q;
  logic [RANK_W-1:0] hit_rank_q, best_rank_q;
  logic [RANK_W:0]   older_q;
  logic              hit_found_q, free_found_q;
  logic              hit_q, evict_q, dirty_out_q;
  logic [ADDR_BITS-2:0] old_tag_q;
  logic [IDXW-1:0]   fp_q, cp_q, fifo_frame;

  assign raddr      = cmd_i.vread ? frame_q : cnt_q[IDXW-1:0];
  assign fifo_frame = in_range(fp_q, n);
  assign tag_we     = cmd_i.update && !hit_q;

  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = frame_q;
    rank_wdata = '0;
    if (cmd_i.finish) begin
      rank_we = 1'b1;
    end else if (cmd_i.touch && pend_q && eidx_q != frame_q && valid_q[eidx_q]
                 && (RANK_W+1)'(rank_rd_q) < older_q && rank_rd_q < RANK_MAX) begin
      rank_we    = 1'b1;
      rank_waddr = eidx_q;
      rank_wdata = rank_rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[frame_q] <= page_q;
    tag_rd_q <= tag_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
    rank_rd_q <= rank_mem[raddr];
  end

  // search: first hit, first free frame, oldest frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan && pend_q) begin
      if (!hit_found_q && valid_q[eidx_q] && tag_rd_q == page_q) hit_found_q <= 1'b1;
      if (!free_found_q && !valid_q[eidx_q]) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && pend_q) begin
      if (!hit_found_q && valid_q[eidx_q] && tag_rd_q == page_q) begin
        hit_idx_q  <= eidx_q;
        hit_rank_q <= rank_rd_q;
      end
      if (!free_found_q && !valid_q[eidx_q]) free_idx_q <= eidx_q;
      if (eidx_q == '0 || rank_rd_q > best_rank_q) begin
        best_idx_q  <= eidx_q;
        best_rank_q <= rank_rd_q;
      end
    end
  end

  // victim selection, pointers and hand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q   <= '0;
      cp_q   <= '0;
      hand_q <= '0;
    end else begin
      if (cmd_i.pick && cmd_i.src == SRC_FIFO)  fp_q <= wrap_next(fifo_frame, n);
      if (cmd_i.pick && cmd_i.src == SRC_CLOCK) cp_q <= wrap_next(hand_q, n);
      if (cmd_i.sweep_init) hand_q <= in_range(cp_q, n);
      else if (cmd_i.sweep_step) hand_q <= wrap_next(hand_q, n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dirty_out_q <= 1'b0;
      old_tag_q   <= '0;
    end
    if (cmd_i.pick) begin
      case (cmd_i.src)
        SRC_HIT: begin
          frame_q <= hit_idx_q;
          older_q <= (RANK_W+1)'(hit_rank_q);
          hit_q   <= 1'b1;
          evict_q <= 1'b0;
        end
        SRC_FREE: begin
          frame_q <= free_idx_q;
          older_q <= (RANK_W+1)'(RANK_MAX) + 1'b1;
          hit_q   <= 1'b0;
          evict_q <= 1'b0;
        end
        SRC_LRU: begin
          frame_q <= best_idx_q;
          hit_q   <= 1'b0;
          evict_q <= 1'b1;
        end
        SRC_FIFO: begin
          frame_q <= fifo_frame;
          hit_q   <= 1'b0;
          evict_q <= 1'b1;
        end
        SRC_CLOCK: begin
          frame_q <= hand_q;
          hit_q   <= 1'b0;
          evict_q <= 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.vcap) begin
      old_tag_q   <= tag_rd_q;
      older_q     <= (RANK_W+1)'(rank_rd_q);
      dirty_out_q <= dirty_q[frame_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      use_q   <= '0;
    end else begin
      if (cmd_i.sweep_step) use_q[hand_q] <= 1'b0;
      if (cmd_i.update) begin
        use_q[frame_q] <= 1'b1;
        if (hit_q) begin
          if (wr_q) dirty_q[frame_q] <= 1'b1;
        end else begin
          valid_q[frame_q] <= 1'b1;
          dirty_q[frame_q] <= wr_q;
        end
      end
    end
  end

  assign status_o.pass_done   = (cnt_q == n) && !pend_q;
  assign status_o.hit_found   = hit_found_q;
  assign status_o.free_found  = free_found_q;
  assign status_o.use_at_hand = use_q[hand_q];
  assign status_o.policy      = pol_cfg_q;

  assign physical_address_o = (ADDR_BITS'(frame_q) << ob) | offset_q;
  assign frame_index_o      = frame_q;
  assign page_fault_o       = !hit_q;
  assign evict_valid_o      = evict_q;
  assign evicted_page_o     = evict_q ? old_tag_q : '0;
  assign dirty_evict_o      = evict_q && dirty_out_q;

  a_frame_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> ((CNTW+1)'(frame_q) < (CNTW+1)'(n)))
    else $error("chosen frame outside the active range");
  a_frame_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (valid_q[frame_q] && use_q[frame_q]))
    else $error("chosen frame not resident at completion");
  a_full_on_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_init |-> (!hit_found_q && !free_found_q))
    else $error("eviction started with a free frame or a hit");

endmodule
`default_nettype wire
